// ===== sv/dls_pkg.sv =====
package dls_pkg;

  localparam int JointsDefault = 5;
  localparam int Rows = 3;
  localparam logic [15:0] DampingReset = 16'd3277;
  localparam logic [31:0] Sat32Max = 32'h7FFF_FFFF;
  localparam logic [31:0] Sat32Min = 32'h8000_0000;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SOLVE = 1'b1;

  // Unit operations
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;

  typedef struct packed {
    logic [2:0]         joint_index;
    logic signed [31:0] joint_rate;
    logic               last;
    logic               singular;
  } result_t;

  // Clamp a wide signed value into the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sh0_7FFF_FFFF) r = Sat32Max;
    else if (x < -66'sh0_8000_0000) r = Sat32Min;
    else r = x[31:0];
    return r;
  endfunction

  // Round a signed value right by k, halves away from zero
  function automatic logic signed [65:0] rshift(input logic signed [65:0] x,
                                                input int unsigned k);
    logic [65:0] mag;
    logic signed [65:0] r;
    mag = x[65] ? 66'(-x) : 66'(x);
    mag = (mag + (66'd1 << (k - 1))) >> k;
    r = x[65] ? -$signed(mag) : $signed(mag);
    return r;
  endfunction

endpackage

// ===== sv/dls_if.sv =====
interface dls_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  row;
  logic [2:0]  column;
  logic signed [15:0] jacobian_value;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;
  modport source(output valid, mode, row, column, jacobian_value, vel_x, vel_y, vel_z,
                 input ready);
  modport sink(input valid, mode, row, column, jacobian_value, vel_x, vel_y, vel_z,
               output ready);
endinterface

interface dls_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  joint_index;
  logic signed [31:0] joint_rate;
  logic        last;
  logic        singular;
  modport source(output valid, joint_index, joint_rate, last, singular, input ready);
  modport sink(input valid, joint_index, joint_rate, last, singular, output ready);
endinterface

interface dls_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== sv/dls_div.sv =====
module dls_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  import dls_pkg::*;

  // Restoring divider, one quotient bit a cycle on 48-bit dividend
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] dvd_r, dvd_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [48:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [48:0] trial;
  logic [49:0] rounded;
  logic [31:0] mag_n, mag_d;

  assign mag_n = num[31] ? 32'(-num) : 32'(num);
  assign mag_d = den[31] ? 32'(-den) : 32'(den);
  assign trial = {rem_r[47:0], dvd_r[47]};

  always_comb begin
    rem_nxt = rem_r; dvd_nxt = dvd_r; dsr_nxt = dsr_r; q_nxt = q_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    if (start) begin
      // Bias by half the divisor so truncation rounds to nearest
      rem_nxt = '0;
      dvd_nxt = {mag_n, 16'd0} + 48'(mag_d >> 1);
      dsr_nxt = mag_d;
      q_nxt = '0;
      cnt_nxt = 6'd48;
      busy_nxt = 1'b1;
      neg_nxt = num[31] ^ den[31];
    end else if (busy_r) begin
      if (trial >= {17'd0, dsr_r}) begin
        rem_nxt = trial - {17'd0, dsr_r};
        q_nxt = {q_r[47:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[47:0], 1'b0};
      end
      dvd_nxt = {dvd_r[46:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Apply the sign to the rounded magnitude, then clamp
  assign rounded = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign quo = sat32(66'($signed(rounded)));
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; dvd_r <= dvd_nxt; dsr_r <= dsr_nxt; q_r <= q_nxt; neg_r <= neg_nxt;
  end
endmodule

// ===== sv/damped_least_squares_joint_rates_top.sv =====
// Channel | Direction | Payload
// in_     | sink      | mode, row, column, jacobian_value, vel_x, vel_y, vel_z
// out_    | source    | joint_index, joint_rate, last, singular
// cfg_    | sink      | data (damping, Q0.16)
// Load beats are accepted while idle. A solve builds M one product at a time
// (S_RD, S_MACC, S_MFIN) with a rounding step per entry, then runs the
// elimination, where each of the six divisions waits on the 48-step divider,
// then forms one output dot product per joint.
// Synchronous active-low reset; the Jacobian store is not cleared.
// in_ready is low during a solve until the last result is loaded; each result
// beat waits in the output register until out_ready.
module damped_least_squares_joint_rates_top #(
  parameter int JOINTS = dls_pkg::JointsDefault
) (
  input logic clk,
  input logic rst_n,
  dls_in_if.sink   in_ch,
  dls_out_if.source out_ch,
  dls_cfg_if.sink  cfg_ch
);
  import dls_pkg::*;

  localparam int Depth = Rows * JOINTS;
  localparam int AW = $clog2(Depth);
  localparam int JW = $clog2(JOINTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MACC = 4'd1;  // build M entries
  localparam logic [3:0] S_MFIN = 4'd2;
  localparam logic [3:0] S_SEQ  = 4'd3;  // solver micro-steps
  localparam logic [3:0] S_DIVW = 4'd4;
  localparam logic [3:0] S_DOT  = 4'd5;
  localparam logic [3:0] S_DFIN = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [15:0] damp_r;
  logic signed [15:0] jac_mem [Depth];
  logic signed [15:0] rd_r;
  logic [AW-1:0] rd_addr;

  // Solver registers, Q.16
  logic signed [31:0] m_r [6];   // m00 m10 m20 m11 m21 m22
  logic signed [31:0] v_r [3];
  logic signed [31:0] x_r [12];  // scratch: l10 l20 d1 t21 l21 d2 y1 y2 w2 w1 w0 tmp
  logic signed [31:0] w_r [3];
  logic signed [65:0] acc_r;
  logic signed [15:0] a_r;
  logic [2:0] ent_r;
  logic [JW-1:0] k_r;
  logic       ph_r;
  logic [4:0] pc_r;
  logic [1:0] rr_r;
  result_t    res_r;
  logic       ov_r;

  // Divider
  logic div_start, div_done;
  logic signed [31:0] div_n, div_d, div_q;
  dls_div u_div (.clk, .rst_n, .start(div_start), .num(div_n), .den(div_d),
                 .done(div_done), .quo(div_q));

  // Entry row/column pairs for M
  function automatic logic [1:0] ent_a(input logic [2:0] e);
    logic [1:0] r;
    case (e)
      3'd0: r = 2'd0; 3'd1: r = 2'd1; 3'd2: r = 2'd2;
      3'd3: r = 2'd1; 3'd4: r = 2'd2; default: r = 2'd2;
    endcase
    return r;
  endfunction
  function automatic logic [1:0] ent_b(input logic [2:0] e);
    logic [1:0] r;
    case (e)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4: r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // Solver program: op, a, b, destination (indices into a value table)
  // value table: 0..5 m, 6..8 v, 9..20 x
  localparam int NP = 20;
  function automatic logic [16:0] prog(input logic [4:0] p);
    logic [16:0] r;
    case (p)
      5'd0:  r = {OP_DIV, 5'd1, 5'd0, 5'd9};    // l10 = m10/d0
      5'd1:  r = {OP_DIV, 5'd2, 5'd0, 5'd10};   // l20 = m20/d0
      5'd2:  r = {OP_MUL, 5'd9, 5'd1, 5'd20};   // tmp = l10*m10
      5'd3:  r = {OP_SUB, 5'd3, 5'd20, 5'd11};  // d1 (check)
      5'd4:  r = {OP_MUL, 5'd10, 5'd1, 5'd20};
      5'd5:  r = {OP_SUB, 5'd4, 5'd20, 5'd12};  // t21
      5'd6:  r = {OP_DIV, 5'd12, 5'd11, 5'd13}; // l21
      5'd7:  r = {OP_MUL, 5'd10, 5'd2, 5'd20};
      5'd8:  r = {OP_SUB, 5'd5, 5'd20, 5'd14};
      5'd9:  r = {OP_MUL, 5'd13, 5'd12, 5'd20};
      5'd10: r = {OP_SUB, 5'd14, 5'd20, 5'd14}; // d2 (check)
      5'd11: r = {OP_MUL, 5'd9, 5'd6, 5'd20};
      5'd12: r = {OP_SUB, 5'd7, 5'd20, 5'd15};  // y1
      5'd13: r = {OP_MUL, 5'd10, 5'd6, 5'd20};
      5'd14: r = {OP_SUB, 5'd8, 5'd20, 5'd16};
      5'd15: r = {OP_MUL, 5'd13, 5'd15, 5'd20};
      5'd16: r = {OP_SUB, 5'd16, 5'd20, 5'd16}; // y2
      5'd17: r = {OP_DIV, 5'd16, 5'd14, 5'd17}; // w2
      5'd18: r = {OP_DIV, 5'd15, 5'd11, 5'd18}; // y1/d1
      5'd19: r = {OP_MUL, 5'd13, 5'd17, 5'd20};
      default: r = {OP_SUB, 5'd18, 5'd20, 5'd18}; // w1
    endcase
    return r;
  endfunction
  // Tail of the program for w0
  localparam int NT = 6;
  function automatic logic [16:0] prog2(input logic [2:0] p);
    logic [16:0] r;
    case (p)
      3'd0: r = {OP_DIV, 5'd6, 5'd0, 5'd19};   // y0/d0
      3'd1: r = {OP_MUL, 5'd9, 5'd18, 5'd20};
      3'd2: r = {OP_SUB, 5'd19, 5'd20, 5'd19};
      3'd3: r = {OP_MUL, 5'd10, 5'd17, 5'd20};
      default: r = {OP_SUB, 5'd19, 5'd20, 5'd19}; // w0
    endcase
    return r;
  endfunction

  logic [16:0] ins;
  logic [1:0]  op;
  logic signed [31:0] opa, opb, res;
  logic signed [63:0] prod;

  function automatic logic signed [31:0] tbl(input logic [4:0] i,
    input logic signed [31:0] m [6], input logic signed [31:0] v [3],
    input logic signed [31:0] x [12]);
    logic signed [31:0] r;
    if (i < 5'd6) r = m[i[2:0]];
    else if (i < 5'd9) r = v[2'(i - 5'd6)];
    else r = x[4'(i - 5'd9)];
    return r;
  endfunction

  assign ins = (pc_r < 5'(NP + 1)) ? prog(pc_r) : prog2(3'(pc_r - 5'(NP + 1)));
  assign op  = ins[16:15];
  assign opa = tbl(ins[14:10], m_r, v_r, x_r);
  assign opb = tbl(ins[9:5], m_r, v_r, x_r);
  assign prod = opa * opb;
  assign res = (op == OP_MUL) ? sat32(rshift(66'(prod), 16)) : sat32(66'(opa) - 66'(opb));
  assign div_n = opa;
  assign div_d = opb;

  // Launch the divider on a divide step unless the first pivot is zero
  logic div_go;
  assign div_go = (state_r == S_SEQ) && (op == OP_DIV)
                  && !(pc_r == 5'd0 && m_r[0] == 32'sd0);

  // Read address: M building walks rows ent_a/ent_b, dot walks rows of joint k
  always_comb begin
    rd_addr = '0;
    if (state_r == S_RD || state_r == S_MACC || state_r == S_MFIN)
      rd_addr = AW'((ph_r ? ent_b(ent_r) : ent_a(ent_r)) * JOINTS + k_r);
    else
      rd_addr = AW'(rr_r * JOINTS + k_r);
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.joint_index = res_r.joint_index;
  assign out_ch.joint_rate = res_r.joint_rate;
  assign out_ch.last = res_r.last;
  assign out_ch.singular = res_r.singular;

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;

  // Store writes and registered reads
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.mode == MODE_LOAD && in_ch.row < 2'(Rows)
        && 32'(in_ch.column) < 32'(JOINTS))
      jac_mem[AW'(in_ch.row * JOINTS + in_ch.column)] <= in_ch.jacobian_value;
    rd_r <= jac_mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      damp_r <= DampingReset;
      ov_r <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= div_go;
      if (cfg_ch.valid) damp_r <= cfg_ch.data;
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.mode == MODE_SOLVE) begin
            v_r[0] <= 32'(in_ch.vel_x) <<< 4;
            v_r[1] <= 32'(in_ch.vel_y) <<< 4;
            v_r[2] <= 32'(in_ch.vel_z) <<< 4;
            ent_r <= '0; k_r <= '0; ph_r <= 1'b0; acc_r <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          // Fetch one element of the pair; read lands next cycle
          ph_r <= 1'b1;
          state_r <= S_MACC;
        end
        S_MACC: begin
          if (ph_r) begin
            a_r <= rd_r;
            ph_r <= 1'b0;
            state_r <= S_MFIN;
          end
        end
        S_MFIN: begin
          if (!ph_r) begin
            // rd_r now holds the second element
            acc_r <= acc_r + 66'(a_r) * 66'(rd_r) * 66'sd256;
            if (32'(k_r) == JOINTS - 1) begin
              ph_r <= 1'b1;
            end else begin
              k_r <= k_r + JW'(1);
              state_r <= S_RD;
            end
          end else begin
            m_r[ent_r] <= sat32(rshift(acc_r + ((ent_r == 3'd0 || ent_r == 3'd3
                                 || ent_r == 3'd5) ? $signed(66'(damp_r) * 66'(damp_r))
                                 : 66'sd0), 16));
            acc_r <= '0; k_r <= '0; ph_r <= 1'b0;
            if (ent_r == 3'd5) begin
              pc_r <= '0;
              state_r <= S_SEQ;
            end else begin
              ent_r <= ent_r + 3'd1;
              state_r <= S_RD;
            end
          end
        end
        S_SEQ: begin
          if (pc_r == 5'd0 && m_r[0] == 32'sd0) begin
            k_r <= '0; state_r <= S_OUT;
          end else if (pc_r == 5'(NP + 1 + NT - 1)) begin
            w_r[0] <= x_r[10]; w_r[1] <= x_r[9]; w_r[2] <= x_r[8];
            k_r <= '0; rr_r <= '0; acc_r <= '0; ph_r <= 1'b0;
            state_r <= S_DOT;
          end else if (op == OP_DIV) begin
            state_r <= S_DIVW;
          end else begin
            x_r[4'(ins[4:0] - 5'd9)] <= res;
            pc_r <= pc_r + 5'd1;
            if ((pc_r == 5'd3 || pc_r == 5'd10) && res == 32'sd0) begin
              k_r <= '0; state_r <= S_OUT;
            end
          end
        end
        S_DIVW: begin
          if (div_done) begin
            x_r[4'(ins[4:0] - 5'd9)] <= div_q;
            pc_r <= pc_r + 5'd1;
            state_r <= S_SEQ;
          end
        end
        S_DOT: begin
          // Address settles this cycle; accumulate next
          if (ph_r) begin
            acc_r <= acc_r + 66'(rd_r) * 66'(w_r[rr_r]);
            ph_r <= 1'b0;
            if (rr_r == 2'd2) state_r <= S_DFIN;
            else rr_r <= rr_r + 2'd1;
          end else begin
            ph_r <= 1'b1;
          end
        end
        S_DFIN: begin
          if (!ov_r) begin
            res_r.joint_index <= 3'(k_r);
            res_r.joint_rate <= sat32(rshift(acc_r, 12));
            res_r.last <= (32'(k_r) == JOINTS - 1);
            res_r.singular <= 1'b0;
            ov_r <= 1'b1;
            acc_r <= '0; rr_r <= '0;
            if (32'(k_r) == JOINTS - 1) state_r <= S_IDLE;
            else begin
              k_r <= k_r + JW'(1);
              state_r <= S_DOT;
            end
          end
        end
        S_OUT: begin
          if (!ov_r) begin
            res_r.joint_index <= 3'(k_r);
            res_r.joint_rate <= '0;
            res_r.last <= (32'(k_r) == JOINTS - 1);
            res_r.singular <= 1'b1;
            ov_r <= 1'b1;
            if (32'(k_r) == JOINTS - 1) state_r <= S_IDLE;
            else k_r <= k_r + JW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
